// File: sv/pidk_pkg.sv
// shared widths, register indexes, reset values and types for the pi drive controller
package pidk_pkg;

    // field and arithmetic widths
    localparam int DIST_W     = 13;
    localparam int SP_W       = 12;
    localparam int KP_W       = 16;
    localparam int KI_W       = 24;
    localparam int LIM_W      = 31;
    localparam int INTEG_W    = 32;
    localparam int ERR_W      = 14;
    localparam int ACC_W      = 33;
    localparam int PPROD_W    = 31;
    localparam int IPROD_W    = 57;
    localparam int SUM_W      = 34;
    localparam int POWER_W    = 8;
    localparam int KP_SHIFT   = 8;
    localparam int KI_SHIFT   = 24;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_SET_POINT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd3;

    // register reset values
    localparam logic [SP_W-1:0]  RST_SET_POINT   = 12'd30;
    localparam logic [KP_W-1:0]  RST_PROP_GAIN   = 16'd512;
    localparam logic [KI_W-1:0]  RST_INTEG_GAIN  = 24'd1678;
    localparam logic [LIM_W-1:0] RST_INTEG_LIMIT = 31'd185000;

    // drive saturation magnitude
    localparam logic signed [POWER_W-1:0] DRIVE_MAX = 8'sd127;

    typedef struct packed {
        logic [SP_W-1:0]  set_point;
        logic [KP_W-1:0]  prop_gain;
        logic [KI_W-1:0]  integ_gain;
        logic [LIM_W-1:0] integ_limit;
    } t_cfg;

endpackage

// File: sv/pidk_in_if.sv
// input channel: kill button level and distance sample
interface pidk_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kill_button;
    logic signed [pidk_pkg::DIST_W-1:0]   distance;

    modport source (output valid, output kill_button, output distance, input ready);
    modport sink   (input valid, input kill_button, input distance, output ready);
endinterface

// File: sv/pidk_out_if.sv
// output channel: motor drive, write flag and halted flag
interface pidk_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pidk_pkg::POWER_W-1:0]  motor_power;
    logic                                 write_motors;
    logic                                 is_halted;

    modport source (output valid, output motor_power, output write_motors, output is_halted,
                    input ready);
    modport sink   (input valid, input motor_power, input write_motors, input is_halted,
                    output ready);
endinterface

// File: sv/pidk_cfg_regs.sv
// configuration register file for the pi drive controller
module pidk_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pidk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output pidk_pkg::t_cfg                   o_cfg
);

    pidk_pkg::t_cfg r_cfg;

    // register writes, truncated to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_point   <= pidk_pkg::RST_SET_POINT;
            r_cfg.prop_gain   <= pidk_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain  <= pidk_pkg::RST_INTEG_GAIN;
            r_cfg.integ_limit <= pidk_pkg::RST_INTEG_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidk_pkg::REG_SET_POINT:   r_cfg.set_point   <= i_cfg_data[pidk_pkg::SP_W-1:0];
                pidk_pkg::REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[pidk_pkg::KP_W-1:0];
                pidk_pkg::REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data[pidk_pkg::KI_W-1:0];
                pidk_pkg::REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[pidk_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/pi_drive_controller_with_kill_toggle.sv
// pi drive controller with kill toggle, pipelined from accepted word to result word;
// one word per cycle while o_out.ready is high; stage 1 does toggle, error, integrate
// and clamp, stage 2 the two gain multiplies (32x24 widest), stage 3 shift, add, saturate
// each stage advances whenever the stage after it is empty or moving, so bubbles collapse
// synchronous active-low reset empties the pipeline, starts halted with a zero integrator
// and loads the register reset values
module pi_drive_controller_with_kill_toggle (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pidk_in_if.sink                          i_in,
    pidk_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [pidk_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pidk_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pidk_pkg::t_cfg w_cfg;

    // controller state
    logic                                   r_held;
    logic                                   r_halted;
    logic signed [pidk_pkg::INTEG_W-1:0]    r_integ;

    // stage valids and enables
    logic r1_v, r2_v, r_out_v;
    logic w_out_en, w_s2_en, w_s1_en, w_acc;

    // stage 1 payload
    logic                                   r1_run, r1_write, r1_halted;
    logic signed [pidk_pkg::ERR_W-1:0]      r1_err;
    logic signed [pidk_pkg::INTEG_W-1:0]    r1_acc;

    // stage 2 payload
    logic                                   r2_run, r2_write, r2_halted;
    logic signed [pidk_pkg::PPROD_W-1:0]    r2_pprod;
    logic signed [pidk_pkg::IPROD_W-1:0]    r2_iprod;

    // output payload
    logic signed [pidk_pkg::POWER_W-1:0]    r_out_power;
    logic                                   r_out_write, r_out_halted;

    // stage 1 combinational
    logic                                   w_toggle, n_halted;
    logic signed [pidk_pkg::ERR_W-1:0]      w_err;
    logic signed [pidk_pkg::ACC_W-1:0]      w_sum, w_lim, w_nlim, w_clamped;

    // stage 2 and 3 combinational
    logic signed [pidk_pkg::PPROD_W-1:0]    w_pprod;
    logic signed [pidk_pkg::IPROD_W-1:0]    w_iprod;
    logic signed [pidk_pkg::SUM_W-1:0]      w_sum_drive, w_max, w_min;
    logic signed [pidk_pkg::POWER_W-1:0]    n_power;

    pidk_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // per-stage flow control
    assign w_out_en   = !r_out_v || o_out.ready;
    assign w_s2_en    = !r2_v || w_out_en;
    assign w_s1_en    = !r1_v || w_s2_en;
    assign i_in.ready = w_s1_en;
    assign w_acc      = i_in.valid && w_s1_en;

    // kill toggle on release
    assign w_toggle = r_held && !i_in.kill_button;
    assign n_halted = r_halted ^ w_toggle;

    // error, integrate and clamp to the symmetric limit
    always_comb begin
        w_err  = {i_in.distance[pidk_pkg::DIST_W-1], i_in.distance}
               - $signed({2'b00, w_cfg.set_point});
        w_sum  = {r_integ[pidk_pkg::INTEG_W-1], r_integ}
               + pidk_pkg::ACC_W'(w_err);
        w_lim  = $signed({2'b00, w_cfg.integ_limit});
        w_nlim = -w_lim;
        if (w_sum >= w_lim) begin
            w_clamped = w_lim;
        end else if (w_sum <= w_nlim) begin
            w_clamped = w_nlim;
        end else begin
            w_clamped = w_sum;
        end
    end

    // controller state update on accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= 1'b0;
            r_halted <= 1'b1;
            r_integ  <= '0;
        end else if (w_acc) begin
            r_held   <= i_in.kill_button;
            r_halted <= n_halted;
            if (!n_halted) begin
                r_integ <= w_clamped[pidk_pkg::INTEG_W-1:0];
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_en)  r1_v    <= w_acc;
            if (w_s2_en)  r2_v    <= r1_v;
            if (w_out_en) r_out_v <= r2_v;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_run    <= !n_halted;
            r1_write  <= w_toggle && n_halted;
            r1_halted <= n_halted;
            r1_err    <= w_err;
            r1_acc    <= w_clamped[pidk_pkg::INTEG_W-1:0];
        end
    end

    // gain multiplies
    assign w_pprod = pidk_pkg::PPROD_W'(r1_err)
                   * pidk_pkg::PPROD_W'($signed({1'b0, w_cfg.prop_gain}));
    assign w_iprod = pidk_pkg::IPROD_W'(r1_acc)
                   * pidk_pkg::IPROD_W'($signed({1'b0, w_cfg.integ_gain}));

    always_ff @(posedge i_clk) begin
        if (w_s2_en && r1_v) begin
            r2_run    <= r1_run;
            r2_write  <= r1_write;
            r2_halted <= r1_halted;
            r2_pprod  <= w_pprod;
            r2_iprod  <= w_iprod;
        end
    end

    // arithmetic shifts, sum and saturate to the drive range
    always_comb begin
        w_sum_drive = pidk_pkg::SUM_W'(r2_pprod >>> pidk_pkg::KP_SHIFT)
                    + pidk_pkg::SUM_W'(r2_iprod >>> pidk_pkg::KI_SHIFT);
        w_max       = pidk_pkg::SUM_W'(pidk_pkg::DRIVE_MAX);
        w_min       = -w_max;
        if (!r2_run) begin
            n_power = '0;
        end else if (w_sum_drive > w_max) begin
            n_power = pidk_pkg::DRIVE_MAX;
        end else if (w_sum_drive < w_min) begin
            n_power = -pidk_pkg::DRIVE_MAX;
        end else begin
            n_power = w_sum_drive[pidk_pkg::POWER_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && r2_v) begin
            r_out_power  <= n_power;
            r_out_write  <= r2_write || r2_run;
            r_out_halted <= r2_halted;
        end
    end

    // result word
    assign o_out.valid        = r_out_v;
    assign o_out.motor_power  = r_out_power;
    assign o_out.write_motors = r_out_write;
    assign o_out.is_halted    = r_out_halted;

    // a halted result never drives the motors
    a_halted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_halted) |-> (o_out.motor_power == '0))
        else $error("halted word carries nonzero drive");

    // a running result always writes the motors
    a_run_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_halted) |-> o_out.write_motors)
        else $error("running word without motor write");

    // saturation never yields the most negative code
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.motor_power != -8'sd128))
        else $error("drive outside symmetric range");

    // reset leaves the controller halted with the button released
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_halted && !r_held && !r1_v && !r2_v && !r_out_v))
        else $error("reset state wrong");

    // integrator only moves on an accepted running word
    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_integ))
        else $error("integrator changed without an accepted word");

endmodule
